// ===== design/one_button_dimmer_control_core_macros.svh =====
// -----------------------------------------------------------------------------
// One button dimmer control core: assertion macros
// Shared helpers for the concurrent checks of the dimmer control logic.
// -----------------------------------------------------------------------------
`ifndef ONE_BUTTON_DIMMER_CONTROL_CORE_MACROS_SVH
`define ONE_BUTTON_DIMMER_CONTROL_CORE_MACROS_SVH

// Check that is switched off while reset is asserted.
`define OBDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that also holds while reset is asserted.
`define OBDC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== design/obdc_pkg.sv =====
// -----------------------------------------------------------------------------
// One button dimmer control package
// Types, codes and constants shared by the dimmer control modules.
// -----------------------------------------------------------------------------
package obdc_pkg;

  localparam int unsigned LevelW = 7;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [LevelW-1:0] LevelMax = 7'd100;
  localparam logic [LevelW-1:0] LevelReset = 7'd50;

  // Event codes carried by the command field.
  typedef enum logic [2:0] {
    CMD_POLL         = 3'd0,
    CMD_SINGLE_CLICK = 3'd1,
    CMD_DOUBLE_CLICK = 3'd2,
    CMD_HOLD_BEGIN   = 3'd3,
    CMD_HOST_POWER   = 3'd4,
    CMD_HOST_LEVEL   = 3'd5
  } obdc_cmd_e;

  // Button tracking phase.
  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_HOLD     = 2'd2
  } obdc_phase_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_PRESET_LEVEL = 3'd0,
    REG_RAMP_STEP    = 3'd1,
    REG_RAMP_MIN     = 3'd2,
    REG_RAMP_MAX     = 3'd3,
    REG_REPEAT_INTVL = 3'd4
  } obdc_reg_e;

  typedef struct packed {
    logic [LevelW-1:0]    preset_level;
    logic [LevelW-1:0]    ramp_step;
    logic [LevelW-1:0]    ramp_min;
    logic [LevelW-1:0]    ramp_max;
    logic [IntervalW-1:0] repeat_interval_ms;
  } obdc_cfg_t;

  typedef struct packed {
    logic              power_state;
    logic [LevelW-1:0] level_state;
    logic              led_power;
    logic [LevelW-1:0] led_target;
    logic              preset_mode;
    logic [LevelW-1:0] saved_level;
    logic              ramp_up;
    obdc_phase_e       button_phase;
    logic [TimeW-1:0]  last_repeat_ms;
  } obdc_state_t;

  localparam obdc_cfg_t CfgReset = '{
    preset_level:       7'd60,
    ramp_step:          7'd5,
    ramp_min:           7'd5,
    ramp_max:           7'd100,
    repeat_interval_ms: 16'd200
  };

  localparam obdc_state_t StateReset = '{
    power_state:    1'b0,
    level_state:    LevelReset,
    led_power:      1'b0,
    led_target:     LevelReset,
    preset_mode:    1'b0,
    saved_level:    LevelReset,
    ramp_up:        1'b1,
    button_phase:   PH_RELEASED,
    last_repeat_ms: '0
  };

endpackage

// ===== design/obdc_in_if.sv =====
// -----------------------------------------------------------------------------
// One button dimmer control event channel
// Valid/ready channel that carries one button or host event per beat.
// -----------------------------------------------------------------------------
interface obdc_in_if
  import obdc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [2:0]            command;
  logic                  button_low;
  logic [TimeW-1:0]      now_ms;
  logic [LevelW-1:0]     host_value;

  modport source (output valid, output command, output button_low,
                  output now_ms, output host_value, input ready);
  modport sink   (input valid, input command, input button_low,
                  input now_ms, input host_value, output ready);
endinterface

// ===== design/obdc_out_if.sv =====
// -----------------------------------------------------------------------------
// One button dimmer control result channel
// Valid/ready channel that carries the light state after each event.
// -----------------------------------------------------------------------------
interface obdc_out_if
  import obdc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              led_on;
  logic [LevelW-1:0] led_level;
  logic              power_on;
  logic [LevelW-1:0] level;
  logic              preset_active;

  modport source (output valid, output led_on, output led_level, output power_on,
                  output level, output preset_active, input ready);
  modport sink   (input valid, input led_on, input led_level, input power_on,
                  input level, input preset_active, output ready);
endinterface

// ===== design/obdc_step.sv =====
// -----------------------------------------------------------------------------
// One button dimmer control state update
// Combinational next state of the light for one button or host event.
// -----------------------------------------------------------------------------
module obdc_step
  import obdc_pkg::*;
(
  input  obdc_state_t       state_i,
  input  obdc_cfg_t         cfg_i,
  input  logic [2:0]        command_i,
  input  logic              button_low_i,
  input  logic [TimeW-1:0]  now_ms_i,
  input  logic [LevelW-1:0] host_value_i,
  output obdc_state_t       state_o
);

  logic signed [LevelW+1:0] ramp_sum;
  logic [LevelW-1:0]        ramp_level;
  logic                     ramp_flip;
  logic [TimeW-1:0]         elapsed;
  logic                     interval_passed;
  logic [LevelW-1:0]        host_level;

  // One ramp step in the current direction, clamped to the ramp bounds.
  always_comb begin
    if (state_i.ramp_up) begin
      ramp_sum = $signed({2'b00, state_i.level_state}) + $signed({2'b00, cfg_i.ramp_step});
    end else begin
      ramp_sum = $signed({2'b00, state_i.level_state}) - $signed({2'b00, cfg_i.ramp_step});
    end
    ramp_flip  = 1'b0;
    ramp_level = ramp_sum[LevelW-1:0];
    if (ramp_sum < $signed({2'b00, cfg_i.ramp_min})) begin
      ramp_flip  = 1'b1;
      ramp_level = cfg_i.ramp_min;
    end else if (ramp_sum > $signed({2'b00, cfg_i.ramp_max})) begin
      ramp_flip  = 1'b1;
      ramp_level = cfg_i.ramp_max;
    end
  end

  // Hold repeat timing, modulo 2^32 on the millisecond counter.
  assign elapsed         = now_ms_i - state_i.last_repeat_ms;
  assign interval_passed = elapsed > {{(TimeW-IntervalW){1'b0}}, cfg_i.repeat_interval_ms};

  // Host level writes saturate at full brightness.
  assign host_level = (host_value_i > LevelMax) ? LevelMax : host_value_i;

  // Event decode.
  always_comb begin
    state_o = state_i;
    case (obdc_cmd_e'(command_i))
      CMD_POLL: begin
        if (state_i.button_phase == PH_RELEASED) begin
          if (button_low_i) begin
            state_o.button_phase = PH_PRESSED;
            if (!state_i.power_state) begin
              state_o.led_power = 1'b1;
            end
          end
        end else if (state_i.button_phase == PH_HOLD && interval_passed) begin
          if (button_low_i) begin
            state_o.last_repeat_ms = now_ms_i;
            state_o.ramp_up        = state_i.ramp_up ^ ramp_flip;
            state_o.preset_mode    = 1'b0;
            state_o.level_state    = ramp_level;
            state_o.led_target     = ramp_level;
            state_o.power_state    = 1'b1;
            if (!state_i.power_state) begin
              state_o.led_power = 1'b1;
            end
          end else begin
            // Release ends the hold and restarts the repeat timer.
            state_o.button_phase   = PH_RELEASED;
            state_o.last_repeat_ms = '0;
          end
        end
      end
      CMD_SINGLE_CLICK: begin
        state_o.power_state  = !state_i.power_state;
        state_o.led_power    = !state_i.power_state;
        state_o.button_phase = PH_RELEASED;
      end
      CMD_DOUBLE_CLICK: begin
        if (state_i.preset_mode) begin
          state_o.preset_mode = 1'b0;
          state_o.level_state = state_i.saved_level;
          state_o.led_target  = state_i.saved_level;
        end else begin
          state_o.preset_mode = 1'b1;
          state_o.level_state = cfg_i.preset_level;
          state_o.led_target  = cfg_i.preset_level;
        end
        state_o.power_state = 1'b1;
        if (!state_i.power_state) begin
          state_o.led_power = 1'b1;
        end
        state_o.button_phase = PH_RELEASED;
      end
      CMD_HOLD_BEGIN: begin
        state_o.button_phase = PH_HOLD;
      end
      CMD_HOST_POWER: begin
        state_o.power_state = |host_value_i;
        state_o.led_power   = |host_value_i;
      end
      CMD_HOST_LEVEL: begin
        state_o.preset_mode = 1'b0;
        state_o.saved_level = host_level;
        state_o.level_state = host_level;
        state_o.led_target  = host_level;
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

// ===== design/one_button_dimmer_control_core.sv =====
// A result beat is valid in the cycle after its event beat is accepted.
// One event per cycle; the state update is a single pass of short
// logic between the state registers, which also serve as the result register.
// An event is taken whenever no result is pending or the pending one leaves.
// Reset (rst_ni low, asynchronous) restores the register defaults and the
// light state: power off, level 50, button released; no result is pending.
// -----------------------------------------------------------------------------
// One button dimmer control core
// Turns button and host events into power and level requests for an LED.
// -----------------------------------------------------------------------------
`include "one_button_dimmer_control_core_macros.svh"

module one_button_dimmer_control_core
  import obdc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  obdc_in_if.sink             in_i,
  obdc_out_if.source          out_o
);

  obdc_cfg_t   cfg_q;
  obdc_state_t state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        in_fire;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      case (obdc_reg_e'(cfg_idx_i))
        REG_PRESET_LEVEL: cfg_q.preset_level       <= cfg_data_i[LevelW-1:0];
        REG_RAMP_STEP:    cfg_q.ramp_step          <= cfg_data_i[LevelW-1:0];
        REG_RAMP_MIN:     cfg_q.ramp_min           <= cfg_data_i[LevelW-1:0];
        REG_RAMP_MAX:     cfg_q.ramp_max           <= cfg_data_i[LevelW-1:0];
        REG_REPEAT_INTVL: cfg_q.repeat_interval_ms <= cfg_data_i[IntervalW-1:0];
        default:          cfg_q <= cfg_q;
      endcase
    end
  end

  // A new event is taken when the result slot is free or drains this cycle.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  obdc_step u_step (
    .state_i      (state_q),
    .cfg_i        (cfg_q),
    .command_i    (in_i.command),
    .button_low_i (in_i.button_low),
    .now_ms_i     (in_i.now_ms),
    .host_value_i (in_i.host_value),
    .state_o      (state_d)
  );

  // Result slot occupancy.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Light state; it only moves on an accepted event beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        state_q <= state_d;
      end
    end
  end

  // The result beat shows the state left by the last event.
  assign out_o.valid         = out_valid_q;
  assign out_o.led_on        = state_q.led_power;
  assign out_o.led_level     = state_q.led_target;
  assign out_o.power_on      = state_q.power_state;
  assign out_o.level         = state_q.level_state;
  assign out_o.preset_active = state_q.preset_mode;

  // Consistency checks.
  `OBDC_ASSERT(a_fire_gives_result, in_fire |=> out_valid_q, "accepted beat gave no result")
  `OBDC_ASSERT(a_state_holds_idle, !in_fire |=> $stable(state_q), "state moved without an event")
  `OBDC_ASSERT_ALWAYS(a_power_lights_led, state_q.power_state |-> state_q.led_power, "power on but LED off")
  `OBDC_ASSERT_ALWAYS(a_target_tracks_level, state_q.led_target == state_q.level_state, "LED target differs from level")

endmodule
